>>> sv/ipa_pkg.sv
package ipa_pkg;

    localparam int ID_W      = 16;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [ID_W-1:0] NONE_ID     = 16'hFFFF;
    localparam logic [ID_W-1:0] START_RESET = 16'h0000;
    localparam logic [ID_W-1:0] END_RESET   = 16'h0100;

    localparam logic CMD_GRAB   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BELOW_START = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ISSUED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL        = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
    } range_t;

    typedef struct packed {
        logic            clear;
        logic [ID_W-1:0] fresh_init;
    } clear_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

>>> sv/id_pool_allocator.sv
// Identifier pool: hands out ids from [range_start, range_end) and takes them back.
// Command channel: a beat is taken at a rising edge with start high and busy low.
// busy stays low, so one command (grab or return) can be issued every cycle.
// command 0 grabs an id: the oldest returned id first, else the next fresh id.
// command 1 returns return_id: the last fresh id rewinds the counter, other ids
// are queued in a FREE_DEPTH-entry free list held in a block RAM.
// Result: done pulses for one cycle with ok, granted_id and status; the command
// beat passes the input register, then the result register. There is no
// backpressure on results; each one is valid only while done is high.
// Throughput is one command per cycle; the free-list RAM is read ahead at the
// next head address so a pop never waits on the registered read.
// Config: cfg_we with cfg_index 0 writes range_start, 1 writes range_end.
// Either write rewinds the fresh counter to range_start and empties the free
// list. Write only while no command is in flight.
// Reset: range_start 0, range_end 256, fresh counter 0, free list empty.
module id_pool_allocator #(
    parameter int FREE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [ipa_pkg::ID_W-1:0]        return_id,
    input  logic                            cfg_we,
    input  logic [ipa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipa_pkg::ID_W-1:0]        cfg_data,
    output logic                            done,
    output logic                            ok,
    output logic [ipa_pkg::ID_W-1:0]        granted_id,
    output logic [ipa_pkg::STAT_W-1:0]      status
);

    import ipa_pkg::*;

    range_t          range_reg, range_next;
    clear_t          clr;
    logic            in_valid_reg;
    logic            in_command_reg;
    logic [ID_W-1:0] in_id_reg;
    logic            res_valid;
    result_t         res;

    assign busy = 1'b0;

    always_comb
    begin
        range_next     = range_reg;
        clr.clear      = cfg_we;
        clr.fresh_init = range_reg.lo;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START:
                begin
                    range_next.lo  = cfg_data;
                    clr.fresh_init = cfg_data;
                end
                REG_END:
                begin
                    range_next.hi = cfg_data;
                end
                default:
                begin
                    range_next = range_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg    <= '{lo: START_RESET, hi: END_RESET};
            in_valid_reg <= 1'b0;
        end
        else
        begin
            range_reg    <= range_next;
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_command_reg <= command;
        in_id_reg      <= return_id;
    end

    ipa_pool #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .range      (range_reg),
        .clr        (clr),
        .in_valid   (in_valid_reg),
        .in_command (in_command_reg),
        .in_id      (in_id_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign done       = res_valid;
    assign ok         = res.ok;
    assign granted_id = res.id;
    assign status     = res.status;

endmodule

>>> sv/ipa_ram.sv
module ipa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read during write at the same address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ipa_pool.sv
module ipa_pool #(
    parameter int FREE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipa_pkg::range_t               range,
    input  ipa_pkg::clear_t               clr,
    input  logic                          in_valid,
    input  logic                          in_command,
    input  logic [ipa_pkg::ID_W-1:0]      in_id,
    output logic                          res_valid,
    output ipa_pkg::result_t              res
);

    import ipa_pkg::*;

    localparam int PTR_W = $clog2(FREE_DEPTH);
    localparam int CNT_W = $clog2(FREE_DEPTH + 1);

    logic [ID_W-1:0]  fresh_reg, fresh_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             byp_valid_reg, byp_valid_next;
    logic [ID_W-1:0]  byp_data_reg;
    logic             res_valid_reg;
    result_t          res_reg, res_next;

    logic             push;
    logic [ID_W-1:0]  ram_q;
    logic [ID_W-1:0]  head_data;
    logic [ID_W-1:0]  fresh_dec;
    logic             range_bad;

    assign range_bad = (range.lo >= range.hi);
    assign fresh_dec = fresh_reg - ID_W'(1);
    // the registered RAM read returns the old word when a push writes the head slot
    assign head_data = byp_valid_reg ? byp_data_reg : ram_q;

    always_comb
    begin
        fresh_next = fresh_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        push       = 1'b0;
        res_next   = '{ok: 1'b0, id: NONE_ID, status: ST_OK};

        if (clr.clear)
        begin
            fresh_next = clr.fresh_init;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (in_valid)
        begin
            if (range_bad)
            begin
                res_next.status = ST_FULL;
            end
            else if (in_command == CMD_GRAB)
            begin
                if (count_reg != '0)
                begin
                    res_next.ok = 1'b1;
                    res_next.id = head_data;
                    head_next   = (head_reg == PTR_W'(FREE_DEPTH - 1)) ? '0
                                                                       : head_reg + PTR_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                end
                else if (fresh_reg < range.hi)
                begin
                    res_next.ok = 1'b1;
                    res_next.id = fresh_reg;
                    fresh_next  = fresh_reg + ID_W'(1);
                end
                else
                begin
                    res_next.status = ST_EXHAUSTED;
                end
            end
            else
            begin
                if (in_id < range.lo)
                begin
                    res_next.status = ST_BELOW_START;
                end
                else if (fresh_reg == range.lo)
                begin
                    res_next.status = ST_NOT_ISSUED;
                end
                else if (in_id == fresh_dec)
                begin
                    res_next.ok = 1'b1;
                    fresh_next  = fresh_dec;
                end
                else if (count_reg == CNT_W'(FREE_DEPTH))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    res_next.ok = 1'b1;
                    push        = 1'b1;
                    tail_next   = (tail_reg == PTR_W'(FREE_DEPTH - 1)) ? '0
                                                                       : tail_reg + PTR_W'(1);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
        end

        byp_valid_next = push && (tail_reg == head_next);
    end

    ipa_ram #(
        .WIDTH (ID_W),
        .DEPTH (FREE_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (in_id),
        .raddr (head_next),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= START_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
            res_valid_reg <= in_valid && !clr.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= in_id;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
